[design/twmg_pkg.sv]
// ----------------------------------------------------------------------------
// twmg_pkg
// shared types and constants of the typed word mutation generator
// ----------------------------------------------------------------------------
package twmg_pkg;

	localparam int SLOT_W   = 6;
	localparam int SLOT_NUM = 1 << SLOT_W;

	// opcodes
	localparam logic OP_INT   = 1'b0;
	localparam logic OP_FLOAT = 1'b1;

	// width codes
	localparam logic [1:0] WC_8  = 2'd0;
	localparam logic [1:0] WC_16 = 2'd1;
	localparam logic [1:0] WC_32 = 2'd2;
	localparam logic [1:0] WC_64 = 2'd3;

	// float field limits
	localparam logic [63:0] EXP32_MAX  = 64'hff;
	localparam logic [63:0] FRAC32_MAX = 64'h7fffff;
	localparam logic [63:0] EXP64_MAX  = 64'h7ff;
	localparam logic [63:0] FRAC64_MAX = 64'hfffffffffffff;

	// number of power-of-two nudges per direction
	localparam logic [3:0] NUDGES32 = 4'd5;
	localparam logic [3:0] NUDGES64 = 4'd10;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		logic        opcode;
		logic [1:0]  width_code;
		logic [63:0] word;
		logic [15:0] position;
	} ctx_t;

	typedef struct packed {
		ctx_t  ctx;
		slot_t slot;
		logic  last;
	} cand_t;

	function automatic logic [63:0] width_mask(input logic [1:0] code);
		logic [63:0] m;
		case (code)
			WC_8:    m = 64'hff;
			WC_16:   m = 64'hffff;
			WC_32:   m = 64'hffffffff;
			default: m = 64'hffffffffffffffff;
		endcase
		return m;
	endfunction

endpackage

[design/twmg_in_if.sv]
// ----------------------------------------------------------------------------
// twmg_in_if
// input channel: one seed word with its kind, width and position
// ----------------------------------------------------------------------------
interface twmg_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [1:0]  width_code;
	logic [63:0] word_value;
	logic [15:0] position;

	modport source(output valid, opcode, width_code, word_value, position, input ready);
	modport sink(input valid, opcode, width_code, word_value, position, output ready);
endinterface

[design/twmg_out_if.sv]
// ----------------------------------------------------------------------------
// twmg_out_if
// output channel: one mutated word per item
// ----------------------------------------------------------------------------
interface twmg_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] new_value;
	logic [15:0] out_position;
	logic        last;
	logic        bad_request;

	modport source(output valid, new_value, out_position, last, bad_request, input ready);
	modport sink(input valid, new_value, out_position, last, bad_request, output ready);
endinterface

[design/twmg_decode.sv]
// ----------------------------------------------------------------------------
// twmg_decode
// stage 1: registers the seed word and builds the mask of slots that emit
// ----------------------------------------------------------------------------
module twmg_decode import twmg_pkg::*; #(
	parameter int ARITH_LIMIT = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	twmg_in_if.sink        seed,
	input  logic           take,
	output logic           valid_s1,
	output ctx_t           ctx_s1,
	output logic [SLOT_NUM-1:0] vec_s1
);

	ctx_t                ctx_d;
	logic [SLOT_NUM-1:0] vec_d;

	assign seed.ready = !valid_s1 || take;

	always_comb begin
		logic [63:0] w;
		logic [63:0] f;
		logic [63:0] fmax;
		logic [63:0] lowm;
		logic [3:0]  nd;
		slot_t       s;
		ctx_d.opcode     = seed.opcode;
		ctx_d.width_code = seed.width_code;
		ctx_d.word       = seed.word_value & width_mask(seed.width_code);
		ctx_d.position   = seed.position;
		w  = ctx_d.word;
		nd = (seed.width_code == WC_64) ? NUDGES64 : NUDGES32;
		vec_d = '0;
		for (int i = 0; i < SLOT_NUM; i++) begin
			s = slot_t'(i);
			// slot layout for floats: part, direction, power
			case ({seed.width_code == WC_64, s[5]})
				2'b00:   begin f = (w >> 23) & EXP32_MAX;  fmax = EXP32_MAX;  end
				2'b01:   begin f = w & FRAC32_MAX;         fmax = FRAC32_MAX; end
				2'b10:   begin f = (w >> 52) & EXP64_MAX;  fmax = EXP64_MAX;  end
				default: begin f = w & FRAC64_MAX;         fmax = FRAC64_MAX; end
			endcase
			lowm = (64'd1 << s[3:0]) - 64'd1;
			if (seed.opcode == OP_INT) begin
				vec_d[i] = (i < 2 * ARITH_LIMIT);
			end else if (!seed.width_code[1]) begin
				// float at 8 or 16 bits: one flagged result
				vec_d[i] = (i == 0);
			end else if (s[3:0] < nd) begin
				if (!s[4])
					vec_d[i] = (f | lowm) != fmax;
				else
					vec_d[i] = (f & ~lowm) != 64'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seed.ready) begin
			valid_s1 <= seed.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seed.ready && seed.valid) begin
			ctx_s1 <= ctx_d;
			vec_s1 <= vec_d;
		end
	end

endmodule

[design/twmg_seq.sv]
// ----------------------------------------------------------------------------
// twmg_seq
// stage 2: walks the slots of one item unless stalled, one slot per cycle
// ----------------------------------------------------------------------------
module twmg_seq import twmg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  ctx_t                ctx_s1,
	input  logic [SLOT_NUM-1:0] vec_s1,
	output logic                take,
	input  logic                ready_s2,
	output logic                valid_s2,
	output cand_t               cand_s2
);

	logic                busy_q;
	slot_t               slot_q;
	ctx_t                ctx_q;
	logic [SLOT_NUM-1:0] vec_q;
	logic [SLOT_NUM-1:0] higher;
	logic                done;
	logic                adv;

	assign higher = vec_q & ({SLOT_NUM{1'b1}} << slot_q) & ~(SLOT_NUM'(1) << slot_q);
	assign done   = (higher == '0);
	assign adv    = busy_q && ready_s2;
	assign take   = valid_s1 && (!busy_q || (adv && done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			slot_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s2)
				valid_s2 <= busy_q && vec_q[slot_q];
			if (take) begin
				busy_q <= 1'b1;
				slot_q <= '0;
			end else if (adv) begin
				if (done)
					busy_q <= 1'b0;
				else
					slot_q <= slot_q + slot_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctx_q <= ctx_s1;
			vec_q <= vec_s1;
		end
		if (ready_s2) begin
			cand_s2.ctx  <= ctx_q;
			cand_s2.slot <= slot_q;
			cand_s2.last <= done;
		end
	end

endmodule

[design/twmg_calc.sv]
// ----------------------------------------------------------------------------
// twmg_calc
// stage 3: forms the mutated word and holds it as the output register
// ----------------------------------------------------------------------------
module twmg_calc import twmg_pkg::*; #(
	parameter int ARITH_LIMIT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s2,
	input  cand_t      cand_s2,
	output logic       ready_s2,
	twmg_out_if.source mutant
);

	localparam logic [SLOT_W:0] LIM = (SLOT_W + 1)'(ARITH_LIMIT);

	logic              valid_s3;
	logic [63:0]       value_s3;
	logic [15:0]       pos_s3;
	logic              last_s3;
	logic              bad_s3;
	logic [63:0]       value_d;
	logic              bad_d;

	assign ready_s2 = !valid_s3 || mutant.ready;

	always_comb begin
		logic [63:0]     w;
		logic [SLOT_W:0] s7;
		logic [SLOT_W:0] j;
		logic            idir;
		logic [51:0]     f;
		logic [51:0]     d;
		logic [51:0]     nf;
		logic [63:0]     iv;
		w     = cand_s2.ctx.word;
		bad_d = (cand_s2.ctx.opcode == OP_FLOAT) && !cand_s2.ctx.width_code[1];
		// integer run: add 1..limit, then subtract 1..limit
		s7   = {1'b0, cand_s2.slot};
		idir = (s7 >= LIM);
		j    = idir ? (s7 - LIM + (SLOT_W + 1)'(1)) : (s7 + (SLOT_W + 1)'(1));
		iv   = idir ? (w - 64'(j)) : (w + 64'(j));
		// float nudges: exponent or fraction by a power of two
		d = 52'd1 << cand_s2.slot[3:0];
		case ({cand_s2.ctx.width_code[0], cand_s2.slot[5]})
			2'b00:   f = {44'd0, w[30:23]};
			2'b01:   f = {29'd0, w[22:0]};
			2'b10:   f = {41'd0, w[62:52]};
			default: f = w[51:0];
		endcase
		nf = cand_s2.slot[4] ? (f - d) : (f + d);
		if (bad_d) begin
			value_d = 64'd0;
		end else if (cand_s2.ctx.opcode == OP_INT) begin
			value_d = iv & width_mask(cand_s2.ctx.width_code);
		end else begin
			case ({cand_s2.ctx.width_code[0], cand_s2.slot[5]})
				2'b00:   value_d = {32'd0, w[31], nf[7:0], w[22:0]};
				2'b01:   value_d = {32'd0, w[31:23], nf[22:0]};
				2'b10:   value_d = {w[63], nf[10:0], w[51:0]};
				default: value_d = {w[63:52], nf};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			value_s3 <= value_d;
			pos_s3   <= cand_s2.ctx.position;
			last_s3  <= cand_s2.last;
			bad_s3   <= bad_d;
		end
	end

	assign mutant.valid        = valid_s3;
	assign mutant.new_value    = value_s3;
	assign mutant.out_position = pos_s3;
	assign mutant.last         = last_s3;
	assign mutant.bad_request  = bad_s3;

endmodule

[design/typed_word_mutation_generator.sv]
// ----------------------------------------------------------------------------
// typed_word_mutation_generator
// emits a run of arithmetic or float-field mutations of one seed word
// ----------------------------------------------------------------------------
// seed channel: one item carries opcode, width_code, word_value, position
// mutant channel: one item per mutated word, last marks the end of a run,
//   bad_request flags a float request at 8 or 16 bits (single zero result)
// an item walks three register stages: decode (s1), slot sequencer (s2),
//   value forming and output register (s3); the first result shows at the
//   earliest once the seed has passed s1, the sequencer, s2 and s3, when slot 0 emits
// the sequencer walks one slot per cycle unless stalled, up to the last
//   emitting slot: integer 2*ARITH_LIMIT slots, 32-bit float up to 53, 64-bit
//   float up to 58, flagged request 1; slots whose nudge leaves the field
//   range or whose power is unused at that width are walked but yield no item
// s1 takes the next seed while the sequencer is busy, so runs follow each
//   other with no gap
// reset clears all valid flags and the sequencer; payload is not reset
// a stall on mutant holds s3, which holds the sequencer and then s1;
//   nothing is lost or repeated
// ----------------------------------------------------------------------------
module typed_word_mutation_generator import twmg_pkg::*; #(
	parameter int ARITH_LIMIT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	twmg_in_if.sink    seed,
	twmg_out_if.source mutant
);

	// stage 1 to sequencer
	logic                valid_s1;
	ctx_t                ctx_s1;
	logic [SLOT_NUM-1:0] vec_s1;
	logic                take;

	// sequencer to value stage
	logic                valid_s2;
	cand_t               cand_s2;
	logic                ready_s2;

	// register the seed and mark which slots produce an item
	twmg_decode #(
		.ARITH_LIMIT(ARITH_LIMIT)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.seed     (seed),
		.take     (take),
		.valid_s1 (valid_s1),
		.ctx_s1   (ctx_s1),
		.vec_s1   (vec_s1)
	);

	// walk the slots, flag the final emitting one
	twmg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ctx_s1   (ctx_s1),
		.vec_s1   (vec_s1),
		.take     (take),
		.ready_s2 (ready_s2),
		.valid_s2 (valid_s2),
		.cand_s2  (cand_s2)
	);

	// form the mutated word and drive the output channel
	twmg_calc #(
		.ARITH_LIMIT(ARITH_LIMIT)
	) u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.cand_s2  (cand_s2),
		.ready_s2 (ready_s2),
		.mutant   (mutant)
	);

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives seed words of both kinds and all widths into the mutation generator
// and checks each mutated word against a run predicted at seed acceptance;
// random gaps on both channels, plus one long mutant stall that backs up
// the seed channel
// ----------------------------------------------------------------------------
module tb import twmg_pkg::*; ();

	localparam int ARITH_LIMIT = 32;
	localparam int NUM_RANDOM  = 360;
	// several times the slowest correct run, which grows with roughly 385 items,
	// up to 64 results each and the longest random stall
	localparam int CYCLE_LIMIT = 8000000;
	// quiet tail waited out before the final verdict
	localparam int DRAIN_CYCLES = 100;
	// long mutant hold-off, started once after this many accepted results
	localparam int HOLD_AFTER  = 600;
	localparam int HOLD_CYCLES = 500;

	localparam logic [63:0] SIGN32 = 64'h80000000;
	localparam logic [63:0] SIGN64 = 64'h8000000000000000;

	// one expected mutated word
	typedef struct packed {
		logic [63:0] value;
		logic [15:0] position;
		logic        last;
		logic        bad;
	} mutant_t;

	logic clk;
	logic arst_n;

	twmg_in_if  seed_ch();
	twmg_out_if mutant_ch();

	typed_word_mutation_generator #(
		.ARITH_LIMIT(ARITH_LIMIT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seed   (seed_ch),
		.mutant (mutant_ch)
	);

	ctx_t    seed_q[$];    // seeds waiting to be offered
	mutant_t mutant_q[$];  // predicted mutated words, oldest first

	int errors       = 0;
	int cycles       = 0;
	int seeds_sent   = 0;
	int mutants_seen = 0;

	// driver-side state
	ctx_t cur_seed = '0;
	bit   offering;
	int   seed_gap;

	// monitor-side state
	int stall_left;

	// long hold-off state
	int hold_left;
	int hold_count;

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------------

	// gap length: mostly none or short, now and then long; zero in quiet phases
	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("ERROR @%0t: %s", $time, what);
	endtask

	task automatic queue_seed(input logic op, input logic [1:0] wc,
			input logic [63:0] word, input logic [15:0] pos);
		ctx_t c;
		c.opcode     = op;
		c.width_code = wc;
		c.word       = word;
		c.position   = pos;
		seed_q = {seed_q, c};
	endtask

	task automatic push_mutant(input logic [63:0] value, input logic [15:0] pos,
			input logic bad);
		mutant_t m;
		m.value    = value;
		m.position = pos;
		m.last     = 1'b0;
		m.bad      = bad;
		mutant_q = {mutant_q, m};
	endtask

	// power-of-two nudges of one float field, upward then downward; a nudge
	// that would leave the field range gives no result
	task automatic push_field_nudges(input logic [63:0] word, input logic [15:0] pos,
			input int shift, input logic [63:0] field_max, input int steps,
			input logic [63:0] keep);
		logic [63:0] fld;
		logic [63:0] base;
		logic [63:0] d;
		int k;
		fld  = (word >> shift) & field_max;
		base = word & keep;
		for (k = 0; k < steps; k++) begin
			d = 64'd1 << k;
			if (fld + d <= field_max)
				push_mutant(base | ((fld + d) << shift), pos, 1'b0);
		end
		for (k = 0; k < steps; k++) begin
			d = 64'd1 << k;
			if (fld >= d)
				push_mutant(base | ((fld - d) << shift), pos, 1'b0);
		end
	endtask

	// whole run of mutated words for one accepted seed
	task automatic predict_mutants(input ctx_t c);
		logic [63:0] mask;
		logic [63:0] w;
		int run_start;
		int j;
		case (c.width_code)
			WC_8:    mask = 64'hff;
			WC_16:   mask = 64'hffff;
			WC_32:   mask = 64'hffffffff;
			default: mask = '1;
		endcase
		w = c.word & mask;
		run_start = mutant_q.size();
		if (c.opcode == OP_INT) begin
			for (j = 1; j <= ARITH_LIMIT; j++)
				push_mutant((w + 64'(j)) & mask, c.position, 1'b0);
			for (j = 1; j <= ARITH_LIMIT; j++)
				push_mutant((w - 64'(j)) & mask, c.position, 1'b0);
		end else if (c.width_code == WC_32) begin
			// exponent 30..23, then fraction 22..0, sign kept
			push_field_nudges(w, c.position, 23, EXP32_MAX, int'(NUDGES32),
				SIGN32 | FRAC32_MAX);
			push_field_nudges(w, c.position, 0, FRAC32_MAX, int'(NUDGES32),
				SIGN32 | (EXP32_MAX << 23));
		end else if (c.width_code == WC_64) begin
			// exponent 62..52, then fraction 51..0, sign kept
			push_field_nudges(w, c.position, 52, EXP64_MAX, int'(NUDGES64),
				SIGN64 | FRAC64_MAX);
			push_field_nudges(w, c.position, 0, FRAC64_MAX, int'(NUDGES64),
				SIGN64 | (EXP64_MAX << 52));
		end else begin
			// float asked at 8 or 16 bits: one flagged zero word
			push_mutant(64'd0, c.position, 1'b1);
		end
		if (mutant_q.size() > run_start)
			mutant_q[mutant_q.size() - 1].last = 1'b1;
	endtask

	task automatic check_mutant();
		mutant_t exp_m;
		if (mutant_q.size() == 0) begin
			report_mismatch($sformatf("unexpected mutant item value=%h pos=%h",
				mutant_ch.new_value, mutant_ch.out_position));
			return;
		end
		exp_m = mutant_q.pop_front();
		if (mutant_ch.new_value !== exp_m.value)
			report_mismatch($sformatf("new_value %h, expected %h",
				mutant_ch.new_value, exp_m.value));
		if (mutant_ch.out_position !== exp_m.position)
			report_mismatch($sformatf("out_position %h, expected %h",
				mutant_ch.out_position, exp_m.position));
		if (mutant_ch.last !== exp_m.last)
			report_mismatch($sformatf("last %b, expected %b (value %h)",
				mutant_ch.last, exp_m.last, exp_m.value));
		if (mutant_ch.bad_request !== exp_m.bad)
			report_mismatch($sformatf("bad_request %b, expected %b",
				mutant_ch.bad_request, exp_m.bad));
	endtask

	// ------------------------------------------------------------------------
	// seed driver: offers queued seeds, predicts a run at each acceptance
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_ch.valid      <= 1'b0;
			seed_ch.opcode     <= OP_INT;
			seed_ch.width_code <= WC_8;
			seed_ch.word_value <= '0;
			seed_ch.position   <= '0;
			offering = 1'b0;
			seed_gap = 0;
		end else begin
			if (seed_ch.valid && seed_ch.ready) begin
				predict_mutants(cur_seed);
				seeds_sent++;
				offering = 1'b0;
				// every third stretch of 40 seeds goes without gaps
				seed_gap = pick_gap((seeds_sent / 40) % 3 == 1);
			end
			if (!offering) begin
				if (seed_gap > 0)
					seed_gap--;
				else if (seed_q.size() > 0) begin
					cur_seed = seed_q.pop_front();
					offering = 1'b1;
				end
			end
			// one assignment per signal per edge, so valid stays high
			// across back-to-back seeds
			seed_ch.valid      <= offering;
			seed_ch.opcode     <= cur_seed.opcode;
			seed_ch.width_code <= cur_seed.width_code;
			seed_ch.word_value <= cur_seed.word;
			seed_ch.position   <= cur_seed.position;
		end
	end

	// ------------------------------------------------------------------------
	// long hold-off: counted here in cycles, started once after HOLD_AFTER
	// accepted results; the block fills and stops taking seeds while the
	// driver keeps offering
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_count <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (mutant_ch.valid && mutant_ch.ready) begin
			hold_count <= hold_count + 1;
			if (hold_count + 1 == HOLD_AFTER)
				hold_left <= HOLD_CYCLES;
		end
	end

	// ------------------------------------------------------------------------
	// mutant monitor: checks each accepted item, then maybe stalls
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mutant_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (mutant_ch.valid && mutant_ch.ready) begin
				check_mutant();
				mutants_seen++;
				stall_left = pick_gap((mutants_seen / 500) % 3 == 1);
			end
			if (stall_left > 0) begin
				stall_left--;
				mutant_ch.ready <= 1'b0;
			end else begin
				mutant_ch.ready <= (hold_left == 0);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		logic        op;
		logic [1:0]  wc;
		logic [63:0] word;
		int          e;
		int          i;

		clk    = 1'b0;
		arst_n = 1'b0;

		// directed: integer runs wrapping at each width, junk above the width
		queue_seed(OP_INT, WC_8, 64'h0, 16'h0000);
		queue_seed(OP_INT, WC_8, 64'hffffffffffffffff, 16'hffff);
		queue_seed(OP_INT, WC_16, 64'h5a5a00000000fff0, 16'h0001);
		queue_seed(OP_INT, WC_32, 64'h00000000ffffffe5, 16'h8000);
		queue_seed(OP_INT, WC_64, 64'hffffffffffffffff, 16'h1234);
		queue_seed(OP_INT, WC_64, 64'h0000000000000010, 16'h7fff);
		// 32-bit float: zero exponent, all-ones exponent, fields at both ends
		queue_seed(OP_FLOAT, WC_32, 64'h0000000080000000, 16'h0002);
		queue_seed(OP_FLOAT, WC_32, 64'h000000007fffffff, 16'hfffe);
		queue_seed(OP_FLOAT, WC_32, 64'h000000003fc00000, 16'h0010);
		queue_seed(OP_FLOAT, WC_32, 64'h00000000787ffff0, 16'h0020);
		queue_seed(OP_FLOAT, WC_32, 64'hdeadbeef3f800000, 16'h0040);
		queue_seed(OP_FLOAT, WC_32, 64'h0000000000000000, 16'h0080);
		// 64-bit float
		queue_seed(OP_FLOAT, WC_64, 64'h0000000000000000, 16'h0100);
		queue_seed(OP_FLOAT, WC_64, 64'hffffffffffffffff, 16'h0200);
		queue_seed(OP_FLOAT, WC_64, 64'h3ff0000000000000, 16'h0400);
		queue_seed(OP_FLOAT, WC_64, 64'hc000000000000100, 16'h0800);
		queue_seed(OP_FLOAT, WC_64, 64'h7fe00000000001ff, 16'h1000);
		queue_seed(OP_FLOAT, WC_64, 64'h801ffffffffffe00, 16'h2000);
		// float asked at 8 and 16 bits
		queue_seed(OP_FLOAT, WC_8, 64'hffffffffffffffff, 16'hffff);
		queue_seed(OP_FLOAT, WC_16, 64'h0123456789abcdef, 16'h0000);
		queue_seed(OP_FLOAT, WC_8, 64'h0, 16'h4000);

		// random seeds; half of the 32- and 64-bit float ones get fields pushed
		// near their limits so the range skips are exercised often
		for (i = 0; i < NUM_RANDOM; i++) begin
			op   = 1'($urandom_range(0, 1));
			wc   = 2'($urandom_range(0, 3));
			word = {$urandom, $urandom};
			if (op == OP_FLOAT && $urandom_range(0, 1) == 1) begin
				if (wc == WC_32) begin
					e = $urandom_range(0, 1) ? $urandom_range(0, 20)
						: 255 - $urandom_range(0, 20);
					word[30:23] = e[7:0];
					if ($urandom_range(0, 1) == 1) begin
						if ($urandom_range(0, 1) == 1)
							word[22:0] = 23'($urandom_range(0, 40));
						else
							word[22:0] = FRAC32_MAX[22:0] - 23'($urandom_range(0, 40));
					end
				end else if (wc == WC_64) begin
					e = $urandom_range(0, 1) ? $urandom_range(0, 600)
						: 2047 - $urandom_range(0, 600);
					word[62:52] = e[10:0];
					if ($urandom_range(0, 1) == 1) begin
						if ($urandom_range(0, 1) == 1)
							word[51:0] = 52'($urandom_range(0, 1100));
						else
							word[51:0] = FRAC64_MAX[51:0] - 52'($urandom_range(0, 1100));
					end
				end
			end
			queue_seed(op, wc, word, 16'($urandom));
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all seeds taken, then all predicted words seen, then a quiet tail
		// so that stray extra items still get flagged
		while (seed_q.size() != 0 || offering)
			@(posedge clk);
		while (mutant_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
